[rtl/intel_hex_record_to_bytes_defines.svh]
// Assertion macros shared by the Intel HEX record decoder RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef INTEL_HEX_RECORD_TO_BYTES_DEFINES_SVH
`define INTEL_HEX_RECORD_TO_BYTES_DEFINES_SVH

// Clocked check, masked while reset is high
`define IHEX_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also holds during reset
`define IHEX_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/ihex_pkg.sv]
// Shared types, codes and helpers for the Intel HEX record decoder.
// No dependencies.
package ihex_pkg;

  // Character codes
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_LF    = 8'h0A;

  // Record parse phases
  localparam logic [2:0] PH_START = 3'd0;
  localparam logic [2:0] PH_LEN   = 3'd1;
  localparam logic [2:0] PH_ADDR  = 3'd2;
  localparam logic [2:0] PH_TYPE  = 3'd3;
  localparam logic [2:0] PH_DATA  = 3'd4;
  localparam logic [2:0] PH_SKIP  = 3'd5;

  // Output byte kinds
  localparam logic [1:0] KIND_ADDR_HI = 2'd0;
  localparam logic [1:0] KIND_ADDR_LO = 2'd1;
  localparam logic [1:0] KIND_DATA    = 2'd2;

  // Digits taken per field: 9 bits covers 2 * 255 data digits
  localparam int unsigned COUNT_W = 9;

  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    logic [1:0] kind;
  } ihex_result_t;

  // Hex digit decode: {is_hex, value}; value is 0 for non-hex characters
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

endpackage

[rtl/ihex_parse.sv]
// Record parser state and per-character step logic.
// Depends on ihex_pkg and intel_hex_record_to_bytes_defines.svh.
`include "intel_hex_record_to_bytes_defines.svh"

module ihex_parse (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  step,
  input  logic [7:0]            ch,
  output ihex_pkg::ihex_result_t res
);
  import ihex_pkg::*;

  logic [2:0]         phase, phase_next;
  logic [COUNT_W-1:0] digit_count, digit_count_next;
  logic [7:0]         record_bytes, record_bytes_next;
  logic [3:0]         first_digit, first_digit_next;
  logic               pair_stopped, pair_stopped_next;

  logic [4:0]         hex;
  logic               is_hex;
  logic [COUNT_W-1:0] count_inc;
  logic [7:0]         pair;

  assign hex       = hex_decode(ch);
  assign is_hex    = hex[4];
  assign count_inc = digit_count + COUNT_W'(1);

  // Pair value as strtol would give it
  always_comb begin
    if (pair_stopped) begin
      pair = 8'd0;
    end else if (is_hex) begin
      pair = {first_digit, hex[3:0]};
    end else begin
      pair = {4'd0, first_digit};
    end
  end

  // Next state and result for the current character
  always_comb begin
    phase_next        = phase;
    digit_count_next  = digit_count;
    record_bytes_next = record_bytes;
    first_digit_next  = first_digit;
    pair_stopped_next = pair_stopped;
    res               = '0;
    res.data          = pair;

    if (ch == CH_LF) begin
      phase_next       = PH_START;
      digit_count_next = '0;
    end else if (phase == PH_START) begin
      phase_next       = (ch == CH_COLON) ? PH_LEN : PH_SKIP;
      digit_count_next = '0;
    end else if (phase == PH_LEN || phase == PH_ADDR || phase == PH_TYPE ||
                 phase == PH_DATA) begin
      digit_count_next = count_inc;
      if (!digit_count[0]) begin
        // first digit of a pair
        first_digit_next  = is_hex ? hex[3:0] : 4'd0;
        pair_stopped_next = !is_hex;
      end else begin
        // second digit completes the pair
        unique case (phase)
          PH_LEN: begin
            record_bytes_next = pair;
            phase_next        = PH_ADDR;
            digit_count_next  = '0;
          end
          PH_ADDR: begin
            res.valid = 1'b1;
            if (count_inc == COUNT_W'(2)) begin
              res.kind = KIND_ADDR_HI;
            end else begin
              res.kind         = KIND_ADDR_LO;
              phase_next       = PH_TYPE;
              digit_count_next = '0;
            end
          end
          PH_TYPE: begin
            phase_next       = (record_bytes == 8'd0) ? PH_SKIP : PH_DATA;
            digit_count_next = '0;
          end
          default: begin
            res.valid = 1'b1;
            res.kind  = KIND_DATA;
            if (count_inc >= {record_bytes, 1'b0}) begin
              phase_next       = PH_SKIP;
              digit_count_next = '0;
            end
          end
        endcase
      end
    end
  end

  // State registers, updated once per processed item
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_START;
      digit_count  <= '0;
      record_bytes <= 8'd0;
      first_digit  <= 4'd0;
      pair_stopped <= 1'b0;
    end else if (step) begin
      phase        <= phase_next;
      digit_count  <= digit_count_next;
      record_bytes <= record_bytes_next;
      first_digit  <= first_digit_next;
      pair_stopped <= pair_stopped_next;
    end
  end

  `IHEX_ASSERT(a_start_count_clear, clk, rst, (phase == PH_START) |-> (digit_count == '0), "digit count not clear at line start")
  `IHEX_ASSERT(a_data_count_bound, clk, rst, (phase == PH_DATA) |-> (digit_count < {record_bytes, 1'b0}), "data digit count past record length")
  `IHEX_ASSERT(a_skip_resets_count, clk, rst, (phase == PH_SKIP) |-> (digit_count == '0), "digit count not clear while skipping")

endmodule

[rtl/intel_hex_record_to_bytes.sv]
// A character waits in the input register until the parser takes it; its byte is then captured in the result register.
// Throughput: one character per cycle; the input register and the result register
// each advance whenever the stage after them can take an item.
// Reset (rst, synchronous): empties both registers and returns the parser to line start.
// Top level of the Intel HEX record decoder.
// Depends on ihex_pkg, ihex_parse and intel_hex_record_to_bytes_defines.svh.
`include "intel_hex_record_to_bytes_defines.svh"

module intel_hex_record_to_bytes (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] char_in,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic [1:0] byte_kind
);
  import ihex_pkg::*;

  logic         char_valid;
  logic [7:0]   char_q;
  logic         advance;
  ihex_result_t res;

  // Character is processed when the result register is free or draining
  assign advance  = char_valid && (!out_valid || out_ready);
  assign in_ready = !char_valid || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      char_valid <= 1'b0;
    end else if (in_ready) begin
      char_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      char_q <= char_in;
    end
  end

  ihex_parse u_parse (
    .clk  (clk),
    .rst  (rst),
    .step (advance),
    .ch   (char_q),
    .res  (res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && res.valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.valid) begin
      out_byte  <= res.data;
      byte_kind <= res.kind;
    end
  end

  `IHEX_ASSERT(a_char_held, clk, rst, (char_valid && !advance) |=> (char_valid && $stable(char_q)), "held item lost from input register")
  `IHEX_ASSERT(a_result_loaded, clk, rst, (advance && res.valid) |=> out_valid, "parser result not captured")
  `IHEX_ASSERT(a_kind_legal, clk, rst, out_valid |-> (byte_kind != 2'd3), "illegal byte kind")

endmodule
